// ===== rtl/egle_pkg.sv =====
// ----------------------------------------------------------------------------
// egle_pkg
// Types and constants shared by the escape guard line editor and its checker.
// ----------------------------------------------------------------------------
package egle_pkg;

   // input item kinds
   localparam logic [2:0] KIND_BYTE     = 3'd0;
   localparam logic [2:0] KIND_TICK     = 3'd1;
   localparam logic [2:0] KIND_READ     = 3'd2;
   localparam logic [2:0] KIND_CONSUMED = 3'd3;
   localparam logic [2:0] KIND_EXIT     = 3'd4;

   // configuration register indexes
   localparam int         CSR_IDX_W   = 2;
   localparam logic [1:0] CSR_SILENCE = 2'd0;
   localparam logic [1:0] CSR_ESC_CHR = 2'd1;
   localparam logic [1:0] CSR_ESC_CNT = 2'd2;

   // register reset values
   localparam logic [7:0] SILENCE_RESET = 8'd20;
   localparam logic [7:0] ESC_CHR_RESET = 8'h2B;
   localparam logic [7:0] ESC_CNT_RESET = 8'd5;

   // character codes
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_BS    = 8'h08;
   localparam logic [7:0] CHR_DEL   = 8'h7F;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TILDE = 8'h7E;
   localparam logic [7:0] CHR_LO_A  = 8'h61;
   localparam logic [7:0] CHR_LO_Z  = 8'h7A;
   localparam logic [7:0] CASE_BIT  = 8'h20;

   // detector mode
   typedef enum logic [1:0] {
      MODE_SIL_BEFORE = 2'd0,
      MODE_ESCAPES    = 2'd1,
      MODE_SIL_AFTER  = 2'd2,
      MODE_ACTIVE     = 2'd3
   } mode_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] char_code;
      logic [4:0] read_index;
   } req_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_char;
      logic       last;
      logic       in_command_mode;
      logic       command_ready;
      logic [5:0] command_length;
      logic [7:0] read_char;
   } rsp_type;

   // result record of one item, before it is split into beats
   typedef struct packed {
      logic       echo_valid;
      logic [1:0] last_beat;
      logic [7:0] chr0;
      logic [7:0] chr1;
      logic [7:0] chr2;
      logic       in_command_mode;
      logic       command_ready;
      logic [5:0] command_length;
      logic       rd_hit;
   } rec_type;

endpackage

// ===== rtl/escape_guard_line_editor_unit.sv =====
// ----------------------------------------------------------------------------
// escape_guard_line_editor_unit
// Guard-time escape detector with an upper-casing command line editor.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | direction | moves
//   --------+--------------------------------+-----------+---------------------
//   req     | req_valid, req_ready, req      | in        | one input item
//   rsp     | rsp_valid, rsp_ready, rsp      | out       | one result item
//   csr     | csr_we, csr_index, csr_wdata   | in        | register write
//
// An item is accepted when req_valid and req_ready are high; its results
// leave through the record stage and then the output register, one per
// cycle while rsp_ready is high: one result for most items, three for a
// backspace or delete that erases a character. The line buffer is a
// synchronous memory with a registered read. Results pass a record stage and
// an output register, so a new item is taken while a result waits. Reset is
// synchronous; the line buffer has no clearing pass and holds anything until
// written. A stalled result side backs up into req_ready once both stages
// are full.
//
module escape_guard_line_editor_unit
   import egle_pkg::*;
#(
   parameter int LINE_MAX = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
   localparam int LEN_W  = $clog2(LINE_MAX + 1);
   localparam int CMP_W  = (LEN_W > 5) ? LEN_W : 5;
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_MAX);

   // configuration registers
   logic [7:0] silence_ticks_ff, escape_char_ff, escape_count_ff;

   // control state
   mode_type   mode_ff, mode_in;
   logic [7:0] silence_ff, silence_in;
   logic [7:0] esc_cnt_ff, esc_cnt_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic       done_ff, done_in;

   // line buffer
   logic [7:0]        line_mem [LINE_MAX];
   logic [7:0]        mem_rd_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;

   // pipeline
   logic    s1_valid_ff;
   rec_type s1_rec_ff, rec_in;
   logic    out_valid_ff;
   rec_type out_rec_ff;
   logic [7:0] out_rd_ff;
   logic [1:0] beat_ff;
   logic    accept, out_load, out_last, out_done;

   // decoded byte
   logic       is_printable, is_delete, is_cr;
   logic [7:0] upper_char;
   logic       has_room, not_empty;
   logic [CMP_W-1:0] ridx_w;

   assign accept   = req_valid && req_ready;
   assign out_last = (beat_ff == out_rec_ff.last_beat);
   assign out_done = out_valid_ff && rsp_ready && out_last;
   assign out_load = s1_valid_ff && (!out_valid_ff || out_done);
   assign req_ready = !s1_valid_ff || out_load;

   assign is_cr        = (req.char_code == CHR_CR);
   assign is_delete    = (req.char_code == CHR_BS) || (req.char_code == CHR_DEL);
   assign is_printable = (req.char_code >= CHR_SPACE) && (req.char_code <= CHR_TILDE);
   assign upper_char   = ((req.char_code >= CHR_LO_A) && (req.char_code <= CHR_LO_Z)) ?
                         (req.char_code & ~CASE_BIT) : req.char_code;
   assign has_room     = (length_ff < LEN_FULL);
   assign not_empty    = (length_ff != '0);
   assign ridx_w       = CMP_W'(req.read_index);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ticks_ff <= SILENCE_RESET;
         escape_char_ff   <= ESC_CHR_RESET;
         escape_count_ff  <= ESC_CNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SILENCE: silence_ticks_ff <= csr_wdata;
            CSR_ESC_CHR: escape_char_ff   <= csr_wdata;
            CSR_ESC_CNT: escape_count_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state of detector and editor
   always_comb begin
      mode_in    = mode_ff;
      silence_in = silence_ff;
      esc_cnt_in = esc_cnt_ff;
      length_in  = length_ff;
      done_in    = done_ff;
      unique case (req.kind)
         KIND_BYTE: begin
            unique case (mode_ff)
               MODE_SIL_BEFORE, MODE_SIL_AFTER: begin
                  mode_in    = MODE_SIL_BEFORE;
                  silence_in = silence_ticks_ff;
               end
               MODE_ESCAPES: begin
                  if (req.char_code == escape_char_ff) begin
                     esc_cnt_in = esc_cnt_ff + 8'd1;
                     if (esc_cnt_in >= escape_count_ff) begin
                        mode_in    = MODE_SIL_AFTER;
                        silence_in = silence_ticks_ff;
                     end
                  end else begin
                     mode_in    = MODE_SIL_BEFORE;
                     silence_in = silence_ticks_ff;
                  end
               end
               default: begin
                  if (!done_ff) begin
                     if (is_cr) begin
                        done_in = 1'b1;
                     end else if (is_delete) begin
                        if (not_empty) length_in = length_ff - LEN_W'(1);
                     end else if (has_room) begin
                        if (is_printable) length_in = length_ff + LEN_W'(1);
                     end else begin
                        mode_in    = MODE_SIL_BEFORE;
                        silence_in = silence_ticks_ff;
                     end
                  end
               end
            endcase
         end
         KIND_TICK: begin
            if (silence_ff != 8'd0) begin
               silence_in = silence_ff - 8'd1;
               if (silence_in == 8'd0) begin
                  if (mode_ff == MODE_SIL_BEFORE) begin
                     mode_in    = MODE_ESCAPES;
                     esc_cnt_in = 8'd0;
                  end else if (mode_ff == MODE_SIL_AFTER) begin
                     mode_in   = MODE_ACTIVE;
                     length_in = '0;
                     done_in   = 1'b1;
                  end
               end
            end
         end
         KIND_CONSUMED: begin
            if (done_ff) begin
               done_in   = 1'b0;
               length_in = '0;
            end
         end
         KIND_EXIT: begin
            mode_in    = MODE_SIL_BEFORE;
            silence_in = silence_ticks_ff;
            done_in    = 1'b0;
            length_in  = '0;
         end
         default: ;
      endcase
   end

   // echo, memory access and result record
   always_comb begin
      rec_in                 = '0;
      mem_we                 = 1'b0;
      mem_re                 = 1'b0;
      mem_waddr              = length_ff[ADDR_W-1:0];
      mem_wdata              = upper_char;
      mem_raddr              = ridx_w[ADDR_W-1:0];
      rec_in.in_command_mode = (mode_in == MODE_ACTIVE);
      rec_in.command_ready   = done_in;
      rec_in.command_length  = 6'(length_in);
      unique case (req.kind)
         KIND_BYTE: begin
            if (mode_ff == MODE_ACTIVE && !done_ff) begin
               if (is_cr) begin
                  rec_in.echo_valid = 1'b1;
                  rec_in.chr0       = CHR_LF;
               end else if (is_delete) begin
                  if (not_empty) begin
                     rec_in.echo_valid = 1'b1;
                     rec_in.last_beat  = 2'd2;
                     rec_in.chr0       = CHR_BS;
                     rec_in.chr1       = CHR_SPACE;
                     rec_in.chr2       = CHR_BS;
                  end
               end else if (has_room && is_printable) begin
                  rec_in.echo_valid = 1'b1;
                  rec_in.chr0       = upper_char;
                  mem_we            = accept;
               end
            end
         end
         KIND_READ: begin
            rec_in.rd_hit = (ridx_w < CMP_W'(length_ff));
            mem_re        = accept;
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SIL_BEFORE;
         silence_ff <= SILENCE_RESET;
         esc_cnt_ff <= 8'd0;
         length_ff  <= '0;
         done_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         silence_ff <= silence_in;
         esc_cnt_ff <= esc_cnt_in;
         length_ff  <= length_in;
         done_ff    <= done_in;
      end
   end

   // line buffer memory
   always_ff @(posedge clock) begin
      if (mem_we) line_mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rd_ff <= line_mem[mem_raddr];
   end

   // record stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (out_load) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) s1_rec_ff <= rec_in;
   end

   // output register and beat counter
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         beat_ff      <= 2'd0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
         beat_ff      <= 2'd0;
      end else if (out_done) begin
         out_valid_ff <= 1'b0;
      end else if (out_valid_ff && rsp_ready) begin
         beat_ff <= beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_rec_ff <= s1_rec_ff;
         out_rd_ff  <= s1_rec_ff.rd_hit ? mem_rd_ff : 8'd0;
      end
   end

   // result fields
   always_comb begin
      rsp                 = '0;
      rsp.echo_valid      = out_rec_ff.echo_valid;
      rsp.last            = out_last;
      rsp.in_command_mode = out_rec_ff.in_command_mode;
      rsp.command_ready   = out_rec_ff.command_ready;
      rsp.command_length  = out_rec_ff.command_length;
      rsp.read_char       = out_rd_ff;
      case (beat_ff)
         2'd0:    rsp.echo_char = out_rec_ff.chr0;
         2'd1:    rsp.echo_char = out_rec_ff.chr1;
         default: rsp.echo_char = out_rec_ff.chr2;
      endcase
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ===== rtl/egle_checker.sv =====
// ----------------------------------------------------------------------------
// egle_rsp_checks
// Port-level checks on the result channel of the line editor.
// ----------------------------------------------------------------------------
module egle_rsp_checks
   import egle_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("result item changed while stalled");

   // echo beats of one item follow without a gap
   a_beats_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp.last |=> rsp_valid)
      else $error("gap inside a multi-beat result");

   // status is the same in every beat of one item
   a_status_same: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp.last |=>
         rsp.command_length == $past(rsp.command_length) &&
         rsp.command_ready == $past(rsp.command_ready) &&
         rsp.in_command_mode == $past(rsp.in_command_mode))
      else $error("status changed between beats of one item");

   // a silent item is a single result with no echo byte
   a_silent_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.echo_valid |-> rsp.last && rsp.echo_char == 8'd0)
      else $error("silent result is not a single final item");

   // echo only happens in command mode
   a_echo_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.echo_valid |-> rsp.in_command_mode)
      else $error("echo outside command mode");

endmodule

bind escape_guard_line_editor_unit egle_rsp_checks u_egle_rsp_checks (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
